>>> hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants for the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W      = 8;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 6;
  localparam int ECNT_W     = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } bcast_t;

endpackage

>>> hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds a word, shifts from either neighbor, compares a key
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [ple_pkg::IDX_W-1:0]             idx,
  input  ple_pkg::bcast_t                       bc,
  input  logic [ple_pkg::DATA_W-1:0]            left_data,
  input  logic [ple_pkg::DATA_W-1:0]            right_data,
  output logic [ple_pkg::DATA_W-1:0]            data,
  output logic                                  match
);
  import ple_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    priority if (bc.ins && (idx > bc.pos)) begin
      data_nxt = left_data;
    end else if (bc.ins && (idx == bc.pos)) begin
      data_nxt = bc.value;
    end else if (bc.del && (idx >= bc.pos)) begin
      // top cell pulls in zero, which clears the vacated slot
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data  = data_r;
  assign match = (data_r == bc.value) && (CMP_W'(idx) < CMP_W'(bc.count));

endmodule

>>> hw/rtl/ple_first_match.sv
// ----------------------------------------------------------------------------
// ple_first_match
// priority encoder: lowest cell whose compare hit
// ----------------------------------------------------------------------------
module ple_first_match (
  input  logic [ple_pkg::LIST_DEPTH-1:0] match,
  output logic                           hit,
  output logic [ple_pkg::IDX_W-1:0]      first_idx
);
  import ple_pkg::*;

  always_comb begin
    first_idx = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign hit = |match;

endmodule

>>> hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed words with insert, delete, read and search
// ----------------------------------------------------------------------------
// Every request takes one clock: it is accepted when start is high (busy
// stays low), the whole row of cells shifts or compares in that same edge,
// and the single result appears on the out_ ports with out_valid for the
// next cycle only, so the receiver must take it then. A new request may be
// issued every cycle and always sees the list left by the one before. The
// list depth is set by LIST_DEPTH in ple_pkg; the search path is one
// compare per cell followed by a priority encoder across the row.
module positional_list_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [ple_pkg::POS_W-1:0]    in_position,
  input  logic signed [31:0]           in_value,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic signed [31:0]           out_read_value,
  output logic [ple_pkg::POS_W-1:0]    out_found_index,
  output logic [ple_pkg::ECNT_W-1:0]   out_element_count
);
  import ple_pkg::*;

  logic                  req;
  bcast_t                bc;
  logic [DATA_W-1:0]     cell_data [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match;
  logic                  hit;
  logic [IDX_W-1:0]      first_idx;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  valid_r;
  status_t               status_r;
  status_t               status_nxt;
  logic [DATA_W-1:0]     rd_r;
  logic [DATA_W-1:0]     rd_nxt;
  logic [POS_W-1:0]      fidx_r;
  logic [POS_W-1:0]      fidx_nxt;
  logic [CNT_W-1:0]      ecnt_r;

  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(LIST_DEPTH);

  assign busy    = 1'b0;
  assign req     = start && !busy;
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    bc.ins     = 1'b0;
    bc.del     = 1'b0;
    bc.pos     = '0;
    bc.count   = count_r;
    bc.value   = in_value;
    status_nxt = ST_OK;
    rd_nxt     = '0;
    fidx_nxt   = '0;
    count_nxt  = count_r;
    unique case (op_t'(in_op))
      OP_INSERT: begin
        if (cnt_ext == DEPTH_CMP) begin
          status_nxt = ST_FULL;
        end else if (pos_ext >= DEPTH_CMP) begin
          status_nxt = ST_RANGE;
        end else begin
          bc.ins = req;
          // position past the end appends at the current count
          bc.pos = (pos_ext < cnt_ext) ? in_position[IDX_W-1:0] : count_r[IDX_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          bc.del    = req;
          bc.pos    = in_position[IDX_W-1:0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_ext >= DEPTH_CMP) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_nxt = cell_data[in_position[IDX_W-1:0]];
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          fidx_nxt = POS_W'(first_idx);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_lo
      assign left_d = '0;
    end else begin : g_lo
      assign left_d = cell_data[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_hi
      assign right_d = '0;
    end else begin : g_hi
      assign right_d = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .idx        (IDX_W'(i)),
      .bc         (bc),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .match      (match[i])
    );
  end

  ple_first_match u_first (
    .match     (match),
    .hit       (hit),
    .first_idx (first_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= req;
      if (req) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      fidx_r   <= fidx_nxt;
      ecnt_r   <= count_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_read_value    = rd_r;
  assign out_found_index   = fidx_r;
  assign out_element_count = ECNT_W'(ecnt_r);

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= DEPTH_CMP)
    else $error("list count above depth");

  a_result_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    req |=> out_valid)
    else $error("request gave no result");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ecnt_r == count_r))
    else $error("reported count differs from held count");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (req && (op_t'(in_op) == OP_INSERT) && (cnt_ext == DEPTH_CMP)) |=>
      ($stable(count_r) && (status_r == ST_FULL)))
    else $error("insert into full list changed the count");
`endif

endmodule
